/* hw/rtl/ed_pkg.sv */
// Edit distance engine: shared types, sizes and helpers.
// Used by ed_cell, ed_array and edit_distance; depends on nothing.
`default_nettype none

package ed_pkg;

    // Longest string held; bytes beyond it are dropped
    localparam int MAX_LEN = 64;
    // Width of a score, a length or a count (holds 0..MAX_LEN)
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int SYM_W   = 8;
    localparam int DIST_W  = 7;
    localparam int DIST_MAX = (1 << DIST_W) - 1;

    // Command codes carried in tuser
    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_FEED   = 2'd1,
        CMD_FINISH = 2'd2
    } ed_cmd_t;

    // One wavefront beat handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] symbol;
        logic [LEN_W-1:0] diag;
        logic [LEN_W-1:0] left;
    } ed_wave_t;

    // Clamp a score to the output field
    function automatic logic [DIST_W-1:0] sat_dist(input logic [LEN_W-1:0] d);
        logic [DIST_W-1:0] r;
        if (int'(d) > DIST_MAX) begin
            r = DIST_W'(DIST_MAX);
        end
        else begin
            r = DIST_W'(d);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/edit_distance.sv */
// Levenshtein edit distance engine, top level with stream ports.
// Depends on ed_pkg and ed_array (which uses ed_cell).
//
// Load beats (tuser 0) store first-string bytes, one per cycle, into a chain of
// MAX_LEN cells. Feed beats (tuser 1) are taken one per cycle: each starts a
// wavefront that walks the chain one cell per clock, through a register in every
// cell. A finish beat (tuser 2) is held off until every wavefront has left the
// chain and the output register is free; it then emits one result beat and
// clears the job. tuser 3 is dropped.
`default_nettype none

module edit_distance (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [ed_pkg::SYM_W-1:0]  s_axis_tdata,   // [7:0] symbol
    input  wire logic [1:0]                s_axis_tuser,   // [1:0] cmd
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic [7:0]                     m_axis_tdata,   // [6:0] distance, [7] zero
    output logic                           m_axis_tuser    // [0] overflow
);
    import ed_pkg::*;

    logic [LEN_W-1:0]  first_length_reg, first_length_next;
    logic [LEN_W-1:0]  second_count_reg, second_count_next;
    logic [LEN_W-1:0]  inflight_reg, inflight_next;
    logic              overflow_reg, overflow_next;
    logic [LEN_W-1:0]  last_dist_reg, last_dist_next;
    logic              out_valid_reg, out_valid_next;
    logic [DIST_W-1:0] out_dist_reg, out_dist_next;
    logic              out_ovf_reg, out_ovf_next;

    logic     in_acc, out_free, is_load, is_feed, is_finish;
    logic     load_go, feed_go, finish_go;
    ed_wave_t wave_head, wave_tail;

    // Handshake
    always_comb
    begin
        is_load   = (s_axis_tuser == CMD_LOAD);
        is_feed   = (s_axis_tuser == CMD_FEED);
        is_finish = (s_axis_tuser == CMD_FINISH);
        out_free  = !out_valid_reg || m_axis_tready;
        s_axis_tready = is_finish ? ((inflight_reg == '0) && out_free) : 1'b1;
        in_acc    = s_axis_tvalid && s_axis_tready;
        load_go   = in_acc && is_load && (second_count_reg == '0)
                    && (first_length_reg < LEN_W'(MAX_LEN));
        feed_go   = in_acc && is_feed && (second_count_reg < LEN_W'(MAX_LEN));
        finish_go = in_acc && is_finish;
    end

    // Wavefront entering cell 0
    always_comb
    begin
        wave_head.valid  = feed_go;
        wave_head.symbol = s_axis_tdata;
        wave_head.diag   = second_count_reg;
        wave_head.left   = second_count_reg + LEN_W'(1);
    end

    ed_array u_array (
        .clk          (clk),
        .rst_n        (rst_n),
        .first_length (first_length_reg),
        .load_go      (load_go),
        .load_symbol  (s_axis_tdata),
        .wave_head    (wave_head),
        .wave_tail    (wave_tail)
    );

    // Job state, in-flight count and result register
    always_comb
    begin
        first_length_next = first_length_reg;
        second_count_next = second_count_reg;
        overflow_next     = overflow_reg;
        inflight_next     = inflight_reg;
        last_dist_next    = wave_tail.valid ? wave_tail.left : last_dist_reg;
        out_valid_next    = out_valid_reg && !m_axis_tready;
        out_dist_next     = out_dist_reg;
        out_ovf_next      = out_ovf_reg;

        if (load_go) begin
            first_length_next = first_length_reg + LEN_W'(1);
        end
        if (in_acc && is_load && (second_count_reg == '0)
            && (first_length_reg >= LEN_W'(MAX_LEN))) begin
            overflow_next = 1'b1;
        end
        if (feed_go) begin
            second_count_next = second_count_reg + LEN_W'(1);
        end
        if (in_acc && is_feed && (second_count_reg >= LEN_W'(MAX_LEN))) begin
            overflow_next = 1'b1;
        end

        case ({feed_go, wave_tail.valid})
            2'b10:   inflight_next = inflight_reg + LEN_W'(1);
            2'b01:   inflight_next = inflight_reg - LEN_W'(1);
            default: inflight_next = inflight_reg;
        endcase

        if (finish_go) begin
            out_valid_next    = 1'b1;
            out_dist_next     = (second_count_reg == '0) ? sat_dist(first_length_reg)
                                                         : sat_dist(last_dist_reg);
            out_ovf_next      = overflow_reg;
            first_length_next = '0;
            second_count_next = '0;
            overflow_next     = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            first_length_reg <= '0;
            second_count_reg <= '0;
            inflight_reg     <= '0;
            overflow_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else begin
            first_length_reg <= first_length_next;
            second_count_reg <= second_count_next;
            inflight_reg     <= inflight_next;
            overflow_reg     <= overflow_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        last_dist_reg <= last_dist_next;
        out_dist_reg  <= out_dist_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_dist_reg};
    assign m_axis_tuser  = out_ovf_reg;

`ifndef SYNTHESIS
    // Finish only with the chain drained
    a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
        finish_go |-> (inflight_reg == '0 && !wave_tail.valid))
        else $error("finish accepted with wavefront in flight");

    // A result appears only after a finish beat
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(finish_go))
        else $error("result without finish");

    // Tail beats only when something was fed
    a_tail_counted: assert property (@(posedge clk) disable iff (!rst_n)
        wave_tail.valid |-> (inflight_reg != '0))
        else $error("tail beat with nothing in flight");

    // In-flight count bounded by chain length
    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= LEN_W'(MAX_LEN))
        else $error("in-flight count overrun");
`endif

endmodule

`default_nettype wire

/* hw/rtl/ed_cell.sv */
// One cell of the edit distance chain: holds one first-string byte and its score.
// Depends on ed_pkg for the wavefront type and widths.
`default_nettype none

module ed_cell (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    active,      // cell holds a loaded byte
    input  wire logic                    load,
    input  wire logic [ed_pkg::SYM_W-1:0] load_symbol,
    input  wire logic [ed_pkg::LEN_W-1:0] load_score,
    input  wire ed_pkg::ed_wave_t         wave_in,
    output ed_pkg::ed_wave_t              wave_out
);
    import ed_pkg::*;

    logic [SYM_W-1:0] char_reg, char_next;
    logic [LEN_W-1:0] score_reg, score_next;
    ed_wave_t         wave_next;
    logic             wave_valid_reg;
    logic [SYM_W-1:0] wave_symbol_reg;
    logic [LEN_W-1:0] wave_diag_reg;
    logic [LEN_W-1:0] wave_left_reg;
    logic [LEN_W-1:0] min_dl, min_all, cell_val;
    logic             match;

    // Recurrence for this column
    always_comb
    begin
        match    = (char_reg == wave_in.symbol);
        min_dl   = (wave_in.diag < wave_in.left) ? wave_in.diag : wave_in.left;
        min_all  = (min_dl < score_reg) ? min_dl : score_reg;
        cell_val = match ? wave_in.diag : (min_all + LEN_W'(1));
    end

    // Next state; an inactive cell forwards the beat untouched
    always_comb
    begin
        char_next  = load ? load_symbol : char_reg;
        score_next = score_reg;
        if (load) begin
            score_next = load_score;
        end
        else if (wave_in.valid && active) begin
            score_next = cell_val;
        end
        wave_next.valid  = wave_in.valid;
        wave_next.symbol = wave_in.symbol;
        wave_next.diag   = active ? score_reg : wave_in.diag;
        wave_next.left   = active ? cell_val  : wave_in.left;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        char_reg        <= char_next;
        score_reg       <= score_next;
        wave_symbol_reg <= wave_next.symbol;
        wave_diag_reg   <= wave_next.diag;
        wave_left_reg   <= wave_next.left;
    end

    // Beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wave_valid_reg <= 1'b0;
        end
        else begin
            wave_valid_reg <= wave_next.valid;
        end
    end

    assign wave_out = '{valid:  wave_valid_reg,
                        symbol: wave_symbol_reg,
                        diag:   wave_diag_reg,
                        left:   wave_left_reg};

endmodule

`default_nettype wire

/* hw/rtl/ed_array.sv */
// Chain of MAX_LEN edit distance cells with load decode; emits the tail beat.
// Depends on ed_pkg and ed_cell.
`default_nettype none

module ed_array (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [ed_pkg::LEN_W-1:0] first_length,
    input  wire logic                     load_go,
    input  wire logic [ed_pkg::SYM_W-1:0] load_symbol,
    input  wire ed_pkg::ed_wave_t         wave_head,
    output ed_pkg::ed_wave_t              wave_tail
);
    import ed_pkg::*;

    ed_wave_t wave [MAX_LEN+1];

    assign wave[0] = wave_head;

    // Cell i is live when i < first_length; loads land at index first_length
    for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
        logic active;
        logic load;
        assign active = (LEN_W'(i) < first_length);
        assign load   = load_go && (first_length == LEN_W'(i));

        ed_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .active      (active),
            .load        (load),
            .load_symbol (load_symbol),
            .load_score  (LEN_W'(i + 1)),
            .wave_in     (wave[i]),
            .wave_out    (wave[i+1])
        );
    end

    assign wave_tail = wave[MAX_LEN];

endmodule

`default_nettype wire
